@@ hw/rtl/wdt_pkg.sv @@
`timescale 1ns / 1ps
// Package for the watchdog timer unit: command codes, control bit positions,
// the state and result structs, and the timeout helper function.
// No dependencies.
package wdt_pkg;

    // Commands carried by one request.
    typedef enum logic [2:0] {
        CMD_TICK       = 3'd0,
        CMD_RESTART    = 3'd1,
        CMD_WRITE_CTRL = 3'd2,
        CMD_READ_CTRL  = 3'd3,
        CMD_WRITE_RSTF = 3'd4,
        CMD_IRQ_ACK    = 3'd5
    } wdt_cmd_t;

    // Control register bit positions.
    localparam int BIT_WDIF = 7;
    localparam int BIT_WDIE = 6;
    localparam int BIT_WDP3 = 5;
    localparam int BIT_WDCE = 4;
    localparam int BIT_WDE  = 3;

    // Bit 3 of the data word carries the reset flag for a reset flag write.
    localparam int BIT_RSTF = 3;

    // Protected bits kept from the old value, and bits taken from the write.
    localparam logic [7:0] KEEP_PROTECTED = 8'h2F;
    localparam logic [7:0] TAKE_WRITTEN   = 8'hD8;

    localparam logic [7:0] WINDOW_RESET = 8'd4;
    localparam int         TICK_WIDTH   = 11;
    localparam int         PRESCALE_MOD = 10;

    typedef struct packed {
        logic [7:0]            control;
        logic [TICK_WIDTH-1:0] tick_count;
        logic                  restart_pending;
        logic                  window_armed;
        logic                  reset_flag;
    } wdt_state_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq;
        logic       system_reset;
        logic       reset_flag_out;
    } wdt_result_t;

    // Timeout in ticks: 2 << (prescale index mod 10), index = {WDP3, WDP2..0}.
    function automatic logic [TICK_WIDTH-1:0] timeout_ticks(input logic [7:0] ctrl);
        logic [3:0] idx;
        logic [3:0] shamt;
        idx   = {ctrl[BIT_WDP3], ctrl[2:0]};
        shamt = (idx >= 4'(PRESCALE_MOD)) ? (idx - 4'(PRESCALE_MOD)) : idx;
        return TICK_WIDTH'(2) << shamt;
    endfunction

endpackage

@@ hw/rtl/wdt_step.sv @@
`timescale 1ns / 1ps
// Next-state and result logic for one watchdog request.
// Depends on wdt_pkg.
module wdt_step #(
    parameter int CYCLE_WIDTH = 32
) (
    input  logic [2:0]             cmd,
    input  logic [7:0]             data,
    input  logic [31:0]            cycle_stamp,
    input  logic [7:0]             window_cycles,
    input  wdt_pkg::wdt_state_t    state,
    input  logic [CYCLE_WIDTH-1:0] last_enable,
    output wdt_pkg::wdt_state_t    state_next,
    output logic [CYCLE_WIDTH-1:0] last_enable_next,
    output wdt_pkg::wdt_result_t   result
);

    logic [CYCLE_WIDTH-1:0]          stamp;
    logic [CYCLE_WIDTH-1:0]          gap;
    logic                            window_open;
    logic [wdt_pkg::TICK_WIDTH-1:0]  tick_inc;
    logic [7:0]                      ctrl_written;
    logic                            irq;
    logic                            system_reset;

    assign stamp       = CYCLE_WIDTH'(cycle_stamp);
    assign gap         = stamp - last_enable;
    assign window_open = state.window_armed && (gap <= CYCLE_WIDTH'(window_cycles));
    assign tick_inc    = state.tick_count + wdt_pkg::TICK_WIDTH'(1);

    always_comb
    begin
        state_next       = state;
        last_enable_next = last_enable;
        irq              = 1'b0;
        system_reset     = 1'b0;
        ctrl_written     = data;

        case (wdt_pkg::wdt_cmd_t'(cmd))
            wdt_pkg::CMD_TICK:
            begin
                if (state.restart_pending)
                begin
                    state_next.tick_count      = '0;
                    state_next.restart_pending = 1'b0;
                end
                else if (state.control[wdt_pkg::BIT_WDIE] || state.control[wdt_pkg::BIT_WDE])
                begin
                    state_next.tick_count = tick_inc;
                    if (tick_inc > wdt_pkg::timeout_ticks(state.control))
                    begin
                        state_next.tick_count = '0;
                        if (state.control[wdt_pkg::BIT_WDIE])
                        begin
                            state_next.control[wdt_pkg::BIT_WDIF] = 1'b1;
                            if (state.control[wdt_pkg::BIT_WDE])
                            begin
                                state_next.control[wdt_pkg::BIT_WDIE] = 1'b0;
                            end
                            irq = 1'b1;
                        end
                        else
                        begin
                            state_next.reset_flag = 1'b1;
                            system_reset          = 1'b1;
                        end
                    end
                end
            end
            wdt_pkg::CMD_RESTART:
            begin
                state_next.restart_pending = 1'b1;
            end
            wdt_pkg::CMD_WRITE_CTRL:
            begin
                // Outside the window, or with the reset flag up, the prescaler
                // holds and WDE can only be set.
                if (!window_open || state.reset_flag)
                begin
                    ctrl_written = (state.control & wdt_pkg::KEEP_PROTECTED)
                                 | (data & wdt_pkg::TAKE_WRITTEN);
                end
                if (ctrl_written[wdt_pkg::BIT_WDCE] || ctrl_written[wdt_pkg::BIT_WDE])
                begin
                    last_enable_next        = stamp;
                    state_next.window_armed = 1'b1;
                end
                ctrl_written[wdt_pkg::BIT_WDCE] = 1'b0;
                // The interrupt flag clears only when a one is written to it.
                ctrl_written[wdt_pkg::BIT_WDIF] = state.control[wdt_pkg::BIT_WDIF]
                                                && !data[wdt_pkg::BIT_WDIF];
                state_next.control = ctrl_written;
            end
            wdt_pkg::CMD_WRITE_RSTF:
            begin
                if (!data[wdt_pkg::BIT_RSTF])
                begin
                    state_next.reset_flag = 1'b0;
                end
            end
            wdt_pkg::CMD_IRQ_ACK:
            begin
                state_next.control[wdt_pkg::BIT_WDIF] = 1'b0;
            end
            default:
            begin
                // Reads and unused codes leave the state alone.
            end
        endcase
    end

    assign result.read_data      = state_next.control;
    assign result.irq            = irq;
    assign result.system_reset   = system_reset;
    assign result.reset_flag_out = state_next.reset_flag;

endmodule

@@ hw/rtl/watchdog_timer_unit_core.sv @@
`timescale 1ns / 1ps
// Watchdog timer unit core, built on wdt_pkg and wdt_step. A request is held
// in the input register, passes through the combinational step logic and is
// captured in the result register. Throughput is one request per cycle while
// the consumer takes results; a full, unread result register stalls it.
// rst_n (asynchronous, active low) clears all watchdog state, sets the change
// window to its reset value WINDOW_RESET and empties both pipeline registers.
module watchdog_timer_unit_core #(
    parameter int CYCLE_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [7:0]  cfg_write_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  cmd,
    input  logic [7:0]  data,
    input  logic [31:0] cycle_stamp,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  read_data,
    output logic        irq,
    output logic        system_reset,
    output logic        reset_flag_out
);

    // Input register: holds one accepted request until the step logic
    // consumes it.
    logic        in_valid_reg;
    logic [2:0]  cmd_reg;
    logic [7:0]  data_reg;
    logic [31:0] stamp_reg;

    // Result register: holds one finished result until the consumer takes it.
    logic                  out_valid_reg;
    wdt_pkg::wdt_result_t  result_reg;
    wdt_pkg::wdt_result_t  result_next;

    // Architectural watchdog state.
    wdt_pkg::wdt_state_t    state_reg;
    wdt_pkg::wdt_state_t    state_next;
    logic [CYCLE_WIDTH-1:0] last_enable_reg;
    logic [CYCLE_WIDTH-1:0] last_enable_next;
    logic [7:0]             window_cycles_reg;

    logic advance;

    // A request in the input register moves on whenever the result register
    // is empty or being drained this cycle. The input register accepts a new
    // request whenever it is empty or its content moves on, so a full result
    // register that is being read does not stall the input side.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg   <= cmd;
            data_reg  <= data;
            stamp_reg <= cycle_stamp;
        end
    end

    // The user must write the change window length only while the unit is idle; the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_cycles_reg <= wdt_pkg::WINDOW_RESET;
        end
        else if (cfg_write_en)
        begin
            window_cycles_reg <= cfg_write_data;
        end
    end

    wdt_step #(
        .CYCLE_WIDTH (CYCLE_WIDTH)
    ) u_step (
        .cmd              (cmd_reg),
        .data             (data_reg),
        .cycle_stamp      (stamp_reg),
        .window_cycles    (window_cycles_reg),
        .state            (state_reg),
        .last_enable      (last_enable_reg),
        .state_next       (state_next),
        .last_enable_next (last_enable_next),
        .result           (result_next)
    );

    // State commits in the same cycle the result is captured, so the next
    // request sees it immediately.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= '0;
            last_enable_reg <= '0;
        end
        else if (advance)
        begin
            state_reg       <= state_next;
            last_enable_reg <= last_enable_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign read_data      = result_reg.read_data;
    assign irq            = result_reg.irq;
    assign system_reset   = result_reg.system_reset;
    assign reset_flag_out = result_reg.reset_flag_out;

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the watchdog timer unit core: a directed table,
// then random request sequences under several change-window settings.
// Depends on wdt_pkg and watchdog_timer_unit_core.
module tb_top;
    import wdt_pkg::*;

    // Command codes that the block does not define; it must just report state.
    localparam logic [2:0] CMD_SPARE_A = 3'd6;
    localparam logic [2:0] CMD_SPARE_B = 3'd7;

    localparam logic [7:0] MASK_WDIF = 8'h01 << BIT_WDIF;
    localparam logic [7:0] MASK_WDIE = 8'h01 << BIT_WDIE;
    localparam logic [7:0] MASK_WDCE = 8'h01 << BIT_WDCE;
    localparam logic [7:0] MASK_WDE  = 8'h01 << BIT_WDE;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write_en = 1'b0;
    logic [7:0]  cfg_write_data = 8'h00;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  cmd = 3'd0;
    logic [7:0]  data = 8'h00;
    logic [31:0] cycle_stamp = 32'h0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  read_data;
    logic        irq;
    logic        system_reset;
    logic        reset_flag_out;

    watchdog_timer_unit_core #(
        .CYCLE_WIDTH(32)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .cfg_write_data(cfg_write_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .data          (data),
        .cycle_stamp   (cycle_stamp),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .read_data     (read_data),
        .irq           (irq),
        .system_reset  (system_reset),
        .reset_flag_out(reset_flag_out)
    );

    always #1 clk = ~clk;

    // Our own copy of the watchdog state and of the change-window register.
    logic [7:0]            wd_ctrl = 8'h00;
    logic [TICK_WIDTH-1:0] wd_ticks = '0;
    logic                  wd_restart = 1'b0;
    logic [31:0]           wd_arm_stamp = 32'h0;
    logic                  wd_armed = 1'b0;
    logic                  wd_rstflag = 1'b0;
    logic [7:0]            wd_window = WINDOW_RESET;

    // Status words the block still owes us, oldest first.
    wdt_result_t pending_status[$];

    int          fail_count = 0;
    bit          calm = 1'b0;       // when set, neither side inserts idle cycles
    logic [31:0] stamp_now = 32'h0; // running CPU cycle count for random requests

    // One row of the directed table. When typed is set, res holds the status
    // that the row must produce; otherwise the predictor supplies it.
    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  wdata;
        logic [31:0] stamp;
        logic        typed;
        wdt_result_t res;
    } dir_row_t;

    dir_row_t dir_tab [0:23];

    // Applies one request to the watchdog state and returns the status that
    // the block should report for it.
    function automatic wdt_result_t watchdog_step(input logic [2:0] op,
                                                  input logic [7:0] wd,
                                                  input logic [31:0] st);
        wdt_result_t r;
        logic [7:0]  prev;
        logic [7:0]  nv;
        logic [31:0] gap;
        logic        open;
        int          idx;
        int          limit;
        r = '0;
        case (op)
            CMD_TICK:
            begin
                if (wd_restart)
                begin
                    // A pending restart wins over counting, enabled or not.
                    wd_ticks = '0;
                    wd_restart = 1'b0;
                end
                else if ((wd_ctrl & (MASK_WDIE | MASK_WDE)) != 8'h00)
                begin
                    wd_ticks = wd_ticks + 1'b1;
                    idx = int'({wd_ctrl[BIT_WDP3], wd_ctrl[2:0]});
                    limit = 2 << (idx % PRESCALE_MOD);
                    if (int'(wd_ticks) > limit)
                    begin
                        wd_ticks = '0;
                        if ((wd_ctrl & MASK_WDIE) != 8'h00)
                        begin
                            // Interrupt mode; with WDE also set, drop WDIE so
                            // that the following timeout resets the system.
                            wd_ctrl = wd_ctrl | MASK_WDIF;
                            if ((wd_ctrl & MASK_WDE) != 8'h00)
                            begin
                                wd_ctrl = wd_ctrl & ~MASK_WDIE;
                            end
                            r.irq = 1'b1;
                        end
                        else
                        begin
                            wd_rstflag = 1'b1;
                            r.system_reset = 1'b1;
                        end
                    end
                end
            end
            CMD_RESTART:
            begin
                wd_restart = 1'b1;
            end
            CMD_WRITE_CTRL:
            begin
                prev = wd_ctrl;
                nv = wd;
                gap = st - wd_arm_stamp;
                open = wd_armed && (gap <= 32'(wd_window));
                // Outside the window, or while the reset flag is up, the
                // prescaler holds and WDE can only be set.
                if (!open || wd_rstflag)
                begin
                    nv = (prev & KEEP_PROTECTED) | (nv & TAKE_WRITTEN);
                end
                if ((nv & (MASK_WDCE | MASK_WDE)) != 8'h00)
                begin
                    wd_arm_stamp = st;
                    wd_armed = 1'b1;
                end
                nv = nv & ~(MASK_WDCE | MASK_WDIF);
                // WDIF survives unless the write carries a one in that bit.
                if (((prev & MASK_WDIF) != 8'h00) && ((wd & MASK_WDIF) == 8'h00))
                begin
                    nv = nv | MASK_WDIF;
                end
                wd_ctrl = nv;
            end
            CMD_WRITE_RSTF:
            begin
                if (!wd[BIT_RSTF])
                begin
                    wd_rstflag = 1'b0;
                end
            end
            CMD_IRQ_ACK:
            begin
                wd_ctrl = wd_ctrl & ~MASK_WDIF;
            end
            default:
            begin
            end
        endcase
        r.read_data = wd_ctrl;
        r.reset_flag_out = wd_rstflag;
        return r;
    endfunction

    // Advances the running cycle count, now and then jumping anywhere so that
    // every stamp bit and the wrap get exercised.
    function automatic logic [31:0] next_stamp();
        if ($urandom_range(0, 99) < 4)
        begin
            stamp_now = $urandom();
        end
        else
        begin
            stamp_now = stamp_now + 32'($urandom_range(1, 3));
        end
        return stamp_now;
    endfunction

    // A control value with random flag bits and, most of the time, a short
    // timeout, so that tick bursts actually reach it.
    function automatic logic [7:0] pick_ctrl();
        logic [7:0] v;
        logic [3:0] idx;
        v = 8'($urandom());
        case ($urandom_range(0, 7))
            0: idx = 4'd0;
            1: idx = 4'd1;
            2: idx = 4'd10;
            3: idx = 4'd11;
            4: idx = 4'd2;
            5: idx = 4'd12;
            default: idx = 4'($urandom());
        endcase
        v[BIT_WDP3] = idx[3];
        v[2:0] = idx[2:0];
        return v;
    endfunction

    // Presents one request after a random idle gap, holds it until the block
    // takes it, and records the status it must produce. The task starts at a
    // falling edge, so valid is never lowered and raised in one time step.
    task automatic send_req(input logic [2:0] op, input logic [7:0] wd,
                            input logic [31:0] st, input logic typed,
                            input wdt_result_t want);
        wdt_result_t guess;
        @(negedge clk);
        while (!calm && ($urandom_range(0, 99) < 37))
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd <= op;
        data <= wd;
        cycle_stamp <= st;
        do
            @(posedge clk);
        while (!in_ready);
        guess = watchdog_step(op, wd, st);
        pending_status.push_back(typed ? want : guess);
    endtask

    // Stops sending and waits until every owed status has come back, then
    // waits out the two-stage pipeline before returning.
    task automatic drain_requests();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_status.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Writes the change-window register; only done with the block idle.
    task automatic set_window(input logic [7:0] v);
        drain_requests();
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_write_data <= v;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        wd_window = v;
    endtask

    // Random traffic, mostly well-formed unlock-and-reprogram sequences and
    // tick bursts, with restarts, acknowledges, flag writes and noise mixed in.
    task automatic run_random(input int n_items, input bit mid_pause);
        int          sent;
        int          pick;
        int          burst;
        bit          paused;
        logic [31:0] st;
        sent = 0;
        paused = 1'b0;
        while (sent < n_items)
        begin
            if (mid_pause && !paused && (sent >= n_items / 2))
            begin
                // Let the block run completely dry once in the middle.
                drain_requests();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 25)
            begin
                // Open the window with WDCE, then write within or just past it.
                st = next_stamp();
                send_req(CMD_WRITE_CTRL, 8'($urandom()) | MASK_WDCE, st, 1'b0, '0);
                st = st + 32'($urandom_range(0, int'(wd_window) + 3));
                stamp_now = st;
                send_req(CMD_WRITE_CTRL, pick_ctrl(), st, 1'b0, '0);
                sent += 2;
            end
            else if (pick < 60)
            begin
                burst = $urandom_range(1, 10);
                repeat (burst)
                begin
                    send_req(CMD_TICK, 8'($urandom()), next_stamp(), 1'b0, '0);
                end
                sent += burst;
            end
            else if (pick < 68)
            begin
                send_req(CMD_RESTART, 8'($urandom()), next_stamp(), 1'b0, '0);
                send_req(CMD_TICK, 8'($urandom()), next_stamp(), 1'b0, '0);
                sent += 2;
            end
            else if (pick < 74)
            begin
                send_req(CMD_IRQ_ACK, 8'($urandom()), next_stamp(), 1'b0, '0);
                sent += 1;
            end
            else if (pick < 80)
            begin
                send_req(CMD_READ_CTRL, 8'($urandom()), next_stamp(), 1'b0, '0);
                sent += 1;
            end
            else if (pick < 88)
            begin
                send_req(CMD_WRITE_RSTF, 8'($urandom()), next_stamp(), 1'b0, '0);
                sent += 1;
            end
            else if (pick < 94)
            begin
                // Stray control write at an arbitrary point in time.
                stamp_now = $urandom();
                send_req(CMD_WRITE_CTRL, 8'($urandom()), stamp_now, 1'b0, '0);
                sent += 1;
            end
            else
            begin
                send_req($urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B,
                         8'($urandom()), next_stamp(), 1'b0, '0);
                sent += 1;
            end
        end
    endtask

    // The receiving side stalls at random unless the calm stretch is on.
    always @(negedge clk)
    begin
        out_ready <= calm || ($urandom_range(0, 99) >= 37);
    end

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Every status the block hands over is matched against the oldest one owed.
    always @(posedge clk)
    begin
        wdt_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_status.size() == 0)
            begin
                $display("%0t: stray status, expected none, actual %0h %0b %0b %0b",
                         $time, read_data, irq, system_reset, reset_flag_out);
                fail_count++;
            end
            else
            begin
                want = pending_status.pop_front();
                check_field("read_data", want.read_data, read_data);
                check_field("irq", 8'(want.irq), 8'(irq));
                check_field("system_reset", 8'(want.system_reset), 8'(system_reset));
                check_field("reset_flag_out", 8'(want.reset_flag_out), 8'(reset_flag_out));
            end
        end
    end

    initial
    begin
        // Directed sequence: reset state, a protected write, an unlock that
        // lands exactly on the window edge with prescale index ten (which
        // wraps to the shortest timeout), an interrupt, then a system reset,
        // writes under the reset flag, both flag-write values, a restart,
        // an unlock across the stamp wrap, a WDIF clear and unused commands.
        dir_tab = '{
            '{CMD_READ_CTRL,  8'h00, 32'd0,         1'b1, '{8'h00, 1'b0, 1'b0, 1'b0}},
            '{CMD_TICK,       8'h00, 32'd1,         1'b1, '{8'h00, 1'b0, 1'b0, 1'b0}},
            '{CMD_IRQ_ACK,    8'h00, 32'd2,         1'b1, '{8'h00, 1'b0, 1'b0, 1'b0}},
            '{CMD_WRITE_CTRL, 8'hFF, 32'd10,        1'b0, '0},
            '{CMD_WRITE_CTRL, 8'h7A, 32'd14,        1'b0, '0},
            '{CMD_TICK,       8'h00, 32'd15,        1'b0, '0},
            '{CMD_TICK,       8'hFF, 32'd16,        1'b0, '0},
            '{CMD_TICK,       8'h00, 32'd17,        1'b0, '0},
            '{CMD_IRQ_ACK,    8'hFF, 32'd18,        1'b0, '0},
            '{CMD_TICK,       8'h00, 32'd19,        1'b0, '0},
            '{CMD_TICK,       8'h00, 32'd19,        1'b0, '0},
            '{CMD_TICK,       8'h00, 32'd19,        1'b0, '0},
            '{CMD_WRITE_CTRL, 8'h10, 32'd20,        1'b0, '0},
            '{CMD_WRITE_RSTF, 8'h08, 32'd21,        1'b0, '0},
            '{CMD_WRITE_RSTF, 8'hF7, 32'd22,        1'b0, '0},
            '{CMD_RESTART,    8'h00, 32'd23,        1'b0, '0},
            '{CMD_TICK,       8'h00, 32'd24,        1'b0, '0},
            '{CMD_WRITE_CTRL, 8'h18, 32'hFFFF_FFFE, 1'b0, '0},
            '{CMD_WRITE_CTRL, 8'h00, 32'h0000_0001, 1'b0, '0},
            '{CMD_WRITE_CTRL, 8'h80, 32'd6,         1'b0, '0},
            '{CMD_SPARE_A,    8'hFF, 32'd7,         1'b0, '0},
            '{CMD_SPARE_B,    8'h00, 32'd8,         1'b0, '0},
            '{CMD_READ_CTRL,  8'hFF, 32'hFFFF_FFFF, 1'b0, '0},
            '{CMD_TICK,       8'hFF, 32'd9,         1'b0, '0}
        };

        // Reset is held and then released on a falling edge.
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < 24; i++)
        begin
            send_req(dir_tab[i].op, dir_tab[i].wdata, dir_tab[i].stamp,
                     dir_tab[i].typed, dir_tab[i].res);
        end
        stamp_now = 32'd100;

        // Random phases under different change windows: closed except for
        // a zero gap, fully open, random, one cycle, and a middle value.
        set_window(8'd0);
        run_random(85, 1'b0);

        // The wide-open window runs without any idle cycles on either side.
        set_window(8'd255);
        calm = 1'b1;
        run_random(85, 1'b0);
        drain_requests();
        calm = 1'b0;

        set_window(8'($urandom()));
        run_random(85, 1'b1);

        set_window(8'd1);
        run_random(85, 1'b0);

        set_window(8'd16);
        run_random(85, 1'b0);

        drain_requests();
        if (fail_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Guard against a hung handshake; far beyond the slowest legal run.
    initial
    begin
        #400000;
        $display("Some tests failed");
        $finish;
    end

endmodule
